@@ design/dicom_explicit_vr_stream_parser_unit_macros.svh @@
// Assertion macros shared by the DICOM stream parser RTL.
// Needs nothing else; each use expands to one labelled concurrent assertion.
`ifndef DICOM_EXPLICIT_VR_STREAM_PARSER_UNIT_MACROS_SVH
`define DICOM_EXPLICIT_VR_STREAM_PARSER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DCMP_ASSERT_HOLDS(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DCMP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ design/dcmp_pkg.sv @@
// Shared constants, types and helpers of the DICOM explicit-VR stream parser.
// No dependencies; imported by the parser top level.
`timescale 1ns / 1ps

package dcmp_pkg;

   localparam int unsigned DCMP_PREAMBLE_BYTES = 128;

   // Result kinds as seen on the result channel.
   localparam logic [2:0] KIND_ROWS      = 3'd0;
   localparam logic [2:0] KIND_COLUMNS   = 3'd1;
   localparam logic [2:0] KIND_PIXEL     = 3'd2;
   localparam logic [2:0] KIND_PIXEL_END = 3'd3;
   localparam logic [2:0] KIND_NOT_DICOM = 3'd4;

   // Two-character VR codes, first character in the low byte.
   localparam logic [15:0] VR_OB = 16'h424F;
   localparam logic [15:0] VR_OW = 16'h574F;
   localparam logic [15:0] VR_OF = 16'h464F;
   localparam logic [15:0] VR_SQ = 16'h5153;
   localparam logic [15:0] VR_UT = 16'h5455;
   localparam logic [15:0] VR_UN = 16'h4E55;

   localparam logic [31:0] MAGIC_DICM     = 32'h4D43_4944;
   localparam logic [31:0] LENGTH_UNDEF   = 32'hFFFF_FFFF;
   localparam logic [15:0] GROUP_PIXEL    = 16'h7FE0;
   localparam logic [15:0] GROUP_IMAGE    = 16'h0028;
   localparam logic [15:0] ELEM_ROWS      = 16'h0010;
   localparam logic [15:0] ELEM_COLUMNS   = 16'h0011;
   localparam logic [15:0] ELEM_PIXEL     = 16'h0010;
   localparam logic [7:0]  DELIM_GROUP_LO = 8'hFE;
   localparam logic [7:0]  DELIM_GROUP_HI = 8'hFF;
   localparam logic [7:0]  DELIM_ELEM_HI  = 8'hE0;
   localparam logic [7:0]  SUB_ITEM       = 8'h00;
   localparam logic [7:0]  SUB_ITEM_END   = 8'h0D;
   localparam logic [7:0]  SUB_SEQ_END    = 8'hDD;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic        last;
   } result_type;

   function automatic logic is_long_vr(input logic [15:0] vr);
      return (vr == VR_OB) || (vr == VR_OW) || (vr == VR_OF) ||
             (vr == VR_SQ) || (vr == VR_UT) || (vr == VR_UN);
   endfunction

   // Merge a byte into a little-endian word when its field position lies in
   // the four-byte window that starts at first.
   function automatic logic [31:0] dcmp_gather(input logic [31:0] word,
                                               input logic [7:0]  b,
                                               input logic [2:0]  pos,
                                               input logic [2:0]  first);
      logic [2:0]  k;
      logic [31:0] r;
      k = pos - first;
      r = word;
      if ((pos >= first) && (k < 3'd4)) begin
         r = word | ({24'd0, b} << {k[1:0], 3'b000});
      end
      return r;
   endfunction

endpackage

@@ design/dicom_explicit_vr_stream_parser_unit.sv @@
// DICOM explicit-VR little-endian stream parser, top level.
// Depends on dcmp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dicom_explicit_vr_stream_parser_unit_macros.svh"

// The parser takes a DICOM file as a stream of byte beats, one byte per beat,
// and can accept a beat in every clock cycle: each byte moves a small state
// machine with its counters and a 32-bit gathering register. It skips the
// preamble, checks the "DICM" magic (reporting not-DICOM once otherwise),
// walks the data elements and emits the Rows and Columns values and every
// 16-bit word of the pixel data with tlast on the final one, or a pixel-end
// result if it has none. After that, or after a bad magic, it ignores bytes until a
// beat arrives with tuser set, which restarts it on that very byte. Results
// pass through a two-entry output stage, so input beats keep flowing while one
// result waits to be taken; the input stalls only when both entries are full.
module dicom_explicit_vr_stream_parser_unit
   import dcmp_pkg::*;
#(
   parameter int unsigned PREAMBLE_BYTES = DCMP_PREAMBLE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] result_value
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast
);

   localparam logic [3:0] PH_PREAMBLE = 4'd0;
   localparam logic [3:0] PH_MAGIC    = 4'd1;
   localparam logic [3:0] PH_TAG      = 4'd2;
   localparam logic [3:0] PH_VR       = 4'd3;
   localparam logic [3:0] PH_LEN32    = 4'd4;
   localparam logic [3:0] PH_LEN16    = 4'd5;
   localparam logic [3:0] PH_SKIP     = 4'd6;
   localparam logic [3:0] PH_RC_LO    = 4'd7;
   localparam logic [3:0] PH_RC_HI    = 4'd8;
   localparam logic [3:0] PH_PIX_LO   = 4'd9;
   localparam logic [3:0] PH_PIX_HI   = 4'd10;
   localparam logic [3:0] PH_ITAG     = 4'd11;
   localparam logic [3:0] PH_IDELIM   = 4'd12;
   localparam logic [3:0] PH_IHDR     = 4'd13;
   localparam logic [3:0] PH_ISKIP    = 4'd14;

   // With no preamble the parser looks for the magic straight away.
   localparam logic [3:0] PH_START = (PREAMBLE_BYTES == 0) ? PH_MAGIC : PH_PREAMBLE;

   // Parser state.
   logic [3:0]  phase_ff, phase_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [15:0] group_ff, group_in;
   logic [15:0] element_ff, element_in;
   logic [15:0] vr_ff, vr_in;
   logic [31:0] value_length_ff, value_length_in;
   logic [31:0] shift_ff, shift_in;
   logic        in_undef_ff, in_undef_in;
   logic        finished_ff, finished_in;

   // Output stage: main entry drives the port, skid entry catches overflow.
   result_type  main_ff, main_in;
   result_type  skid_ff, skid_in;
   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic        accept;
   logic        pop;
   logic        push;
   result_type  result;

   // State as seen by this byte, after a possible restart.
   logic [3:0]  ph;
   logic [31:0] bc;
   logic [15:0] grp;
   logic [15:0] elm;
   logic [15:0] vr;
   logic [31:0] vl;
   logic [31:0] sw;
   logic        und;
   logic        fin;

   logic [7:0]  b;
   logic [31:0] bc_inc;
   logic [31:0] bc_dec;
   logic [2:0]  take_total;
   logic [2:0]  take_first;
   logic        take_done;
   logic [31:0] sw_take;
   logic        do_header;
   logic [31:0] hdr_len;
   logic        is_pix;
   logic        is_rc;
   logic [31:0] vl_dec;
   logic [15:0] word16;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign pop        = main_valid_ff && rsp_tready;

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff.value;
   assign rsp_tuser  = main_ff.kind;
   assign rsp_tlast  = main_ff.last;

   always_comb begin
      b   = req_tdata;
      ph  = req_tuser ? PH_START : phase_ff;
      bc  = req_tuser ? 32'd0 : byte_count_ff;
      grp = req_tuser ? 16'd0 : group_ff;
      elm = req_tuser ? 16'd0 : element_ff;
      vr  = req_tuser ? 16'd0 : vr_ff;
      vl  = req_tuser ? 32'd0 : value_length_ff;
      sw  = req_tuser ? 32'd0 : shift_ff;
      und = req_tuser ? 1'b0 : in_undef_ff;
      fin = req_tuser ? 1'b0 : finished_ff;

      bc_inc = bc + 32'd1;
      bc_dec = bc - 32'd1;
      vl_dec = vl - 32'd1;
      word16 = {b, sw[7:0]};

      // Field sizes of the multi-byte header fields.
      case (ph)
         PH_VR, PH_LEN16: take_total = 3'd2;
         PH_LEN32:        take_total = 3'd6;
         default:         take_total = 3'd4;
      endcase
      take_first = ((ph == PH_LEN32) || (ph == PH_IHDR)) ? 3'd2 : 3'd0;
      take_done  = bc_inc >= {29'd0, take_total};
      sw_take    = dcmp_gather(sw, b, bc[2:0], take_first);

      is_pix = (grp == GROUP_PIXEL) && (elm == ELEM_PIXEL);
      is_rc  = (grp == GROUP_IMAGE) && ((elm == ELEM_ROWS) || (elm == ELEM_COLUMNS));

      phase_in        = ph;
      byte_count_in   = bc;
      group_in        = grp;
      element_in      = elm;
      vr_in           = vr;
      value_length_in = vl;
      shift_in        = sw;
      in_undef_in     = und;
      finished_in     = fin;
      push            = 1'b0;
      result          = '0;
      do_header       = 1'b0;
      hdr_len         = 32'd0;

      if (!fin) begin
         unique case (ph)
            PH_PREAMBLE: begin
               byte_count_in = bc_inc;
               if (bc_inc >= 32'(PREAMBLE_BYTES)) begin
                  byte_count_in = 32'd0;
                  phase_in      = PH_MAGIC;
               end
            end
            PH_MAGIC: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  shift_in = 32'd0;
                  if (sw_take != MAGIC_DICM) begin
                     finished_in = 1'b1;
                     push        = 1'b1;
                     result.kind = KIND_NOT_DICOM;
                  end else begin
                     phase_in = PH_TAG;
                  end
               end
            end
            PH_TAG: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  group_in   = sw_take[15:0];
                  element_in = sw_take[31:16];
                  shift_in   = 32'd0;
                  phase_in   = PH_VR;
               end
            end
            PH_VR: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  vr_in    = sw_take[15:0];
                  shift_in = 32'd0;
                  phase_in = is_long_vr(sw_take[15:0]) ? PH_LEN32 : PH_LEN16;
               end
            end
            PH_LEN16: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  do_header = 1'b1;
                  hdr_len   = {16'd0, sw_take[15:0]};
               end
            end
            PH_LEN32: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  shift_in = 32'd0;
                  if (sw_take == LENGTH_UNDEF) begin
                     value_length_in = 32'd0;
                     in_undef_in     = 1'b1;
                     phase_in        = PH_ITAG;
                  end else begin
                     do_header = 1'b1;
                     hdr_len   = sw_take;
                  end
               end
            end
            PH_SKIP, PH_ISKIP: begin
               if (bc != 32'd0) begin
                  byte_count_in = bc_dec;
               end
               if ((bc == 32'd0) || (bc == 32'd1)) begin
                  phase_in = (ph == PH_SKIP) ? PH_TAG : PH_ITAG;
               end
            end
            PH_RC_LO: begin
               shift_in      = {24'd0, b};
               byte_count_in = bc_dec;
               phase_in      = (bc_dec != 32'd0) ? PH_RC_HI : PH_TAG;
            end
            PH_RC_HI: begin
               shift_in      = 32'd0;
               byte_count_in = bc_dec;
               phase_in      = (bc_dec != 32'd0) ? PH_SKIP : PH_TAG;
               push          = 1'b1;
               result.kind   = (elm == ELEM_ROWS) ? KIND_ROWS : KIND_COLUMNS;
               result.value  = word16;
            end
            PH_PIX_LO: begin
               shift_in = {24'd0, b};
               phase_in = PH_PIX_HI;
            end
            PH_PIX_HI: begin
               shift_in        = 32'd0;
               value_length_in = vl_dec;
               push            = 1'b1;
               result.kind     = KIND_PIXEL;
               result.value    = word16;
               if (vl_dec == 32'd0) begin
                  finished_in = 1'b1;
                  result.last = 1'b1;
               end else begin
                  phase_in = PH_PIX_LO;
               end
            end
            PH_ITAG: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  shift_in = 32'd0;
                  if ((sw_take[7:0] == DELIM_GROUP_LO) && (sw_take[15:8] == DELIM_GROUP_HI) &&
                      (sw_take[31:24] == DELIM_ELEM_HI)) begin
                     // Other delimiter-group tags are four bytes that are dropped.
                     if ((sw_take[23:16] == SUB_ITEM) || (sw_take[23:16] == SUB_ITEM_END)) begin
                        phase_in = PH_IDELIM;
                     end else if (sw_take[23:16] == SUB_SEQ_END) begin
                        in_undef_in = 1'b0;
                        phase_in    = PH_IDELIM;
                     end
                  end else begin
                     phase_in = PH_IHDR;
                  end
               end
            end
            PH_IDELIM: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  shift_in = 32'd0;
                  if (und) begin
                     phase_in = PH_ITAG;
                  end else begin
                     do_header = 1'b1;
                     hdr_len   = 32'd0;
                  end
               end
            end
            PH_IHDR: begin
               byte_count_in = take_done ? 32'd0 : bc_inc;
               shift_in      = sw_take;
               if (take_done) begin
                  byte_count_in = {16'd0, sw_take[15:0]};
                  shift_in      = 32'd0;
                  phase_in      = (sw_take[15:0] != 16'd0) ? PH_ISKIP : PH_ITAG;
               end
            end
            default: begin
               finished_in = 1'b1;
            end
         endcase

         // Element length is known: decide what its value bytes mean.
         if (do_header) begin
            value_length_in = hdr_len;
            byte_count_in   = 32'd0;
            shift_in        = 32'd0;
            if (vr == VR_SQ) begin
               // A sequence value is parsed as nested elements.
               if (is_pix) begin
                  finished_in = 1'b1;
                  push        = 1'b1;
                  result.kind = KIND_PIXEL_END;
               end else begin
                  phase_in = PH_TAG;
               end
            end else if (is_pix) begin
               value_length_in = {1'b0, hdr_len[31:1]};
               if (hdr_len[31:1] == 31'd0) begin
                  finished_in = 1'b1;
                  push        = 1'b1;
                  result.kind = KIND_PIXEL_END;
               end else begin
                  phase_in = PH_PIX_LO;
               end
            end else if (is_rc) begin
               byte_count_in = hdr_len;
               phase_in      = (hdr_len != 32'd0) ? PH_RC_LO : PH_TAG;
            end else begin
               byte_count_in = hdr_len;
               phase_in      = (hdr_len != 32'd0) ? PH_SKIP : PH_TAG;
            end
         end
      end
   end

   // Output stage next state. A new result is only taken while the skid
   // entry is free, which the input ready already guarantees.
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept && push;
         end
      end else if (accept && push) begin
         if (!main_valid_ff) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         byte_count_ff   <= 32'd0;
         group_ff        <= 16'd0;
         element_ff      <= 16'd0;
         vr_ff           <= 16'd0;
         value_length_ff <= 32'd0;
         shift_ff        <= 32'd0;
         in_undef_ff     <= 1'b0;
         finished_ff     <= 1'b0;
         main_valid_ff   <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            byte_count_ff   <= byte_count_in;
            group_ff        <= group_in;
            element_ff      <= element_in;
            vr_ff           <= vr_in;
            value_length_ff <= value_length_in;
            shift_ff        <= shift_in;
            in_undef_ff     <= in_undef_in;
            finished_ff     <= finished_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `DCMP_ASSERT_HOLDS(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff, "skid entry full while main entry empty")
   `DCMP_ASSERT_HOLDS(a_last_only_pixel, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_PIXEL, "tlast on a result that is not a pixel word")
   `DCMP_ASSERT_HOLDS(a_tag_count_small, clock, reset, phase_ff == PH_TAG, byte_count_ff < 32'd4, "tag byte position out of range")
   `DCMP_ASSERT_NEXT(a_finished_sticks, clock, reset, finished_ff && !(accept && req_tuser), finished_ff, "parser left the finished state without a restart")

endmodule

@@ tb/dicom_explicit_vr_stream_parser_unit_test.sv @@
// Self-checking testbench for the DICOM explicit-VR stream parser.
// Needs dcmp_pkg and the parser top level; builds whole files as byte beats and
// checks every result beat against its own model of the parser.
`timescale 1ns / 1ps

module dicom_explicit_vr_stream_parser_unit_test;
   import dcmp_pkg::*;

   localparam int unsigned PREAMBLE_LEN = DCMP_PREAMBLE_BYTES;
   localparam int unsigned TARGET_ITEMS = 1850;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;

   // Tag groups and words that the stimulus needs beyond the package set.
   localparam logic [15:0] ITEM_GROUP = {DELIM_GROUP_HI, DELIM_GROUP_LO};
   localparam logic [15:0] VR_US      = 16'h5355;
   localparam logic [15:0] VR_UL      = 16'h4C55;
   localparam logic [15:0] VR_CS      = 16'h5343;
   localparam logic [15:0] VR_LO      = 16'h4F4C;

   // Parser phases of the prediction.
   typedef enum logic [3:0] {
      PH_PREAMBLE, PH_MAGIC, PH_TAG, PH_VR, PH_LEN32, PH_LEN16, PH_SKIP,
      PH_RC_LO, PH_RC_HI, PH_PIX_LO, PH_PIX_HI, PH_ITAG, PH_IDELIM, PH_IHDR,
      PH_ISKIP
   } parse_phase_e;

   // Ways of encoding the pixel data element.
   typedef enum logic [1:0] {PIXF_WIDE, PIXF_SHORT, PIXF_UNDEF, PIXF_SQ} pix_form_e;

   // The scoreboard carries its own copy of the parser state. Each accepted
   // byte beat moves it on and queues whatever result that byte causes.
   class parse_scoreboard;
      int unsigned  preamble_len;
      parse_phase_e phase;
      logic [31:0]  count, group_w, elem_w, vr_w, length_w, gather_w;
      logic         in_seq, done;
      result_type   pending_results[$];
      int unsigned  failures;

      function new(int unsigned pre);
         preamble_len = pre;
         failures = 0;
         restart();
      endfunction

      static function logic wide_vr(logic [15:0] vr);
         return (vr == VR_OB) || (vr == VR_OW) || (vr == VR_OF) ||
                (vr == VR_SQ) || (vr == VR_UT) || (vr == VR_UN);
      endfunction

      function void restart();
         phase    = (preamble_len == 0) ? PH_MAGIC : PH_PREAMBLE;
         count    = 0;
         group_w  = 0;
         elem_w   = 0;
         vr_w     = 0;
         length_w = 0;
         gather_w = 0;
         in_seq   = 0;
         done     = 0;
      endfunction

      function void queue_result(logic [2:0] k, logic [15:0] v, logic l);
         result_type r;
         r.kind  = k;
         r.value = v;
         r.last  = l;
         pending_results = {pending_results, r};
      endfunction

      // Gathers little-endian bytes at field positions first..first+3 and says
      // when the field of total bytes is complete.
      function logic take(logic [7:0] b, int unsigned total, int unsigned first);
         logic [31:0] pos;
         pos = count;
         if (pos >= first && pos - first < 4) begin
            gather_w = gather_w | ({24'd0, b} << (8 * (pos - first)));
         end
         count++;
         if (count >= total) begin
            count = 0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // The element length is known; choose how its value bytes are treated.
      function void end_header();
         logic pix, rc;
         pix = (group_w[15:0] == GROUP_PIXEL) && (elem_w[15:0] == ELEM_PIXEL);
         rc  = (group_w[15:0] == GROUP_IMAGE) &&
               ((elem_w[15:0] == ELEM_ROWS) || (elem_w[15:0] == ELEM_COLUMNS));
         count    = 0;
         gather_w = 0;
         if (vr_w[15:0] == VR_SQ) begin
            if (pix) begin
               done = 1;
               queue_result(KIND_PIXEL_END, 16'd0, 1'b0);
            end else begin
               phase = PH_TAG;
            end
         end else if (pix) begin
            length_w = length_w >> 1;
            if (length_w == 0) begin
               done = 1;
               queue_result(KIND_PIXEL_END, 16'd0, 1'b0);
            end else begin
               phase = PH_PIX_LO;
            end
         end else begin
            count = length_w;
            if (length_w == 0) phase = PH_TAG;
            else phase = rc ? PH_RC_LO : PH_SKIP;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic s);
         logic [31:0] w;
         logic [15:0] v;
         if (s) restart();
         if (done) return;
         case (phase)
            PH_PREAMBLE: begin
               count++;
               if (count >= preamble_len) begin
                  count = 0;
                  phase = PH_MAGIC;
               end
            end
            PH_MAGIC: begin
               if (take(b, 4, 0)) begin
                  w = gather_w;
                  gather_w = 0;
                  if (w != MAGIC_DICM) begin
                     done = 1;
                     queue_result(KIND_NOT_DICOM, 16'd0, 1'b0);
                  end else begin
                     phase = PH_TAG;
                  end
               end
            end
            PH_TAG: begin
               if (take(b, 4, 0)) begin
                  group_w  = {16'd0, gather_w[15:0]};
                  elem_w   = {16'd0, gather_w[31:16]};
                  gather_w = 0;
                  phase    = PH_VR;
               end
            end
            PH_VR: begin
               if (take(b, 2, 0)) begin
                  vr_w     = {16'd0, gather_w[15:0]};
                  gather_w = 0;
                  phase    = wide_vr(vr_w[15:0]) ? PH_LEN32 : PH_LEN16;
               end
            end
            PH_LEN16: begin
               if (take(b, 2, 0)) begin
                  length_w = {16'd0, gather_w[15:0]};
                  end_header();
               end
            end
            PH_LEN32: begin
               if (take(b, 6, 2)) begin
                  length_w = gather_w;
                  gather_w = 0;
                  if (length_w == LENGTH_UNDEF) begin
                     length_w = 0;
                     in_seq   = 1;
                     phase    = PH_ITAG;
                  end else begin
                     end_header();
                  end
               end
            end
            PH_SKIP: begin
               if (count > 0) count--;
               if (count == 0) phase = PH_TAG;
            end
            PH_RC_LO: begin
               gather_w = {24'd0, b};
               count--;
               phase = (count != 0) ? PH_RC_HI : PH_TAG;
            end
            PH_RC_HI: begin
               v = {b, gather_w[7:0]};
               gather_w = 0;
               count--;
               phase = (count != 0) ? PH_SKIP : PH_TAG;
               queue_result((elem_w[15:0] == ELEM_ROWS) ? KIND_ROWS : KIND_COLUMNS, v, 1'b0);
            end
            PH_PIX_LO: begin
               gather_w = {24'd0, b};
               phase = PH_PIX_HI;
            end
            PH_PIX_HI: begin
               v = {b, gather_w[7:0]};
               gather_w = 0;
               length_w--;
               if (length_w == 0) begin
                  done = 1;
                  queue_result(KIND_PIXEL, v, 1'b1);
               end else begin
                  phase = PH_PIX_LO;
                  queue_result(KIND_PIXEL, v, 1'b0);
               end
            end
            PH_ITAG: begin
               if (take(b, 4, 0)) begin
                  w = gather_w;
                  gather_w = 0;
                  if (w[7:0] == DELIM_GROUP_LO && w[15:8] == DELIM_GROUP_HI &&
                      w[31:24] == DELIM_ELEM_HI) begin
                     // Items, item ends and sequence ends are followed by a length to pass
                     // over; any other delimiter-like tag is dropped alone.
                     if (w[23:16] == SUB_ITEM || w[23:16] == SUB_ITEM_END) begin
                        phase = PH_IDELIM;
                     end else if (w[23:16] == SUB_SEQ_END) begin
                        in_seq = 0;
                        phase  = PH_IDELIM;
                     end
                  end else begin
                     phase = PH_IHDR;
                  end
               end
            end
            PH_IDELIM: begin
               if (take(b, 4, 0)) begin
                  gather_w = 0;
                  if (in_seq) begin
                     phase = PH_ITAG;
                  end else begin
                     length_w = 0;
                     end_header();
                  end
               end
            end
            PH_IHDR: begin
               if (take(b, 4, 2)) begin
                  count    = {16'd0, gather_w[15:0]};
                  gather_w = 0;
                  phase    = (count != 0) ? PH_ISKIP : PH_ITAG;
               end
            end
            PH_ISKIP: begin
               if (count > 0) count--;
               if (count == 0) phase = PH_ITAG;
            end
            default: done = 1;
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            if (failures < 10) begin
               $display("unexpected result: kind %0d value %h last %b",
                        got.kind, got.value, got.last);
            end
            failures++;
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.last !== want.last) begin
            if (failures < 10) begin
               $display("result mismatch: expected kind %0d value %h last %b, got kind %0d value %h last %b",
                        want.kind, want.value, want.last, got.kind, got.value, got.last);
            end
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] result_value
   logic [2:0]  rsp_tuser;   // [2:0] kind
   logic        rsp_tlast;

   parse_scoreboard sb;
   logic [7:0]      stream_q[$];      // bytes of the file being built
   int unsigned     counted_items;
   int unsigned     cycle_count;
   logic            steady;           // when set, neither side idles

   dicom_explicit_vr_stream_parser_unit #(
      .PREAMBLE_BYTES(PREAMBLE_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // File construction. Every helper appends little-endian bytes.
   // ---------------------------------------------------------------------
   function automatic void put8(logic [7:0] v);
      stream_q = {stream_q, v};
   endfunction

   function automatic void put16(logic [15:0] v);
      put8(v[7:0]);
      put8(v[15:8]);
   endfunction

   function automatic void put32(logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endfunction

   function automatic void put_rand(int unsigned n);
      repeat (n) put8(8'($urandom));
   endfunction

   // A group that names none of the elements the parser reacts to.
   function automatic logic [15:0] free_group();
      logic [15:0] g;
      g = 16'($urandom);
      if (g == GROUP_PIXEL || g == GROUP_IMAGE || g == ITEM_GROUP) g = 16'h0008;
      return g;
   endfunction

   function automatic logic [15:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_short_vr();
      case ($urandom_range(0, 3))
         0: return VR_US;
         1: return VR_UL;
         2: return VR_CS;
         default: return VR_LO;
      endcase
   endfunction

   function automatic logic [15:0] pick_wide_vr();
      case ($urandom_range(0, 4))
         0: return VR_OB;
         1: return VR_OW;
         2: return VR_OF;
         3: return VR_UT;
         default: return VR_UN;
      endcase
   endfunction

   function automatic void put_header(logic [15:0] g, logic [15:0] e, logic [15:0] vr,
                                      logic [31:0] len);
      put16(g);
      put16(e);
      put16(vr);
      if (parse_scoreboard::wide_vr(vr)) begin
         put16(16'($urandom));     // reserved bytes
         put32(len);
      end else begin
         put16(len[15:0]);
      end
   endfunction

   function automatic void begin_file(logic bad_magic);
      int unsigned k;
      stream_q.delete();
      put_rand(PREAMBLE_LEN);
      put32(MAGIC_DICM);
      if (bad_magic) begin
         k = $urandom_range(0, 3);
         stream_q[PREAMBLE_LEN + k] = stream_q[PREAMBLE_LEN + k] ^ 8'($urandom_range(1, 255));
      end
   endfunction

   function automatic void add_plain();
      logic [15:0] vr;
      int unsigned len;
      vr  = $urandom_range(0, 1) ? pick_short_vr() : pick_wide_vr();
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      put_header(free_group(), 16'($urandom), vr, len);
      put_rand(len);
   endfunction

   function automatic void add_rc(logic cols, int unsigned len, logic wide, logic [15:0] val);
      put_header(GROUP_IMAGE, cols ? ELEM_COLUMNS : ELEM_ROWS, wide ? VR_OB : VR_US, len);
      if (len > 0) put8(val[7:0]);
      if (len > 1) put8(val[15:8]);
      if (len > 2) put_rand(len - 2);
   endfunction

   function automatic int unsigned pick_rc_len();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         7: return 3;
         8: return 4;
         9: return $urandom_range(5, 12);
         default: return 2;
      endcase
   endfunction

   // Undefined-length element: items with nested short elements, stray
   // delimiter tags and item ends, closed by a sequence end.
   function automatic void add_walk(logic [15:0] g, logic [15:0] e, logic [15:0] vr);
      int unsigned r, nl;
      logic [7:0]  sub;
      put_header(g, e, vr, LENGTH_UNDEF);
      repeat ($urandom_range(0, 2)) begin
         put16(ITEM_GROUP);
         put16({DELIM_ELEM_HI, SUB_ITEM});
         put_rand(4);
         repeat ($urandom_range(0, 2)) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               sub = 8'($urandom);
               if (sub == SUB_ITEM || sub == SUB_ITEM_END || sub == SUB_SEQ_END) sub = 8'h01;
               put16(ITEM_GROUP);
               put16({DELIM_ELEM_HI, sub});
            end else begin
               // A nested Rows tag must not be reported.
               put16((r < 30) ? GROUP_IMAGE : free_group());
               put16((r < 30) ? ELEM_ROWS : 16'($urandom));
               put16(16'($urandom));
               nl = $urandom_range(0, 6);
               put16(16'(nl));
               put_rand(nl);
            end
         end
         put16(ITEM_GROUP);
         put16({DELIM_ELEM_HI, SUB_ITEM_END});
         put_rand(4);
      end
      put16(ITEM_GROUP);
      put16({DELIM_ELEM_HI, SUB_SEQ_END});
      put_rand(4);
   endfunction

   function automatic void add_element(int unsigned depth);
      int unsigned r;
      logic [31:0] seq_len;
      r = (depth > 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
      if (r < 30 || (r >= 60 && r < 75 && depth >= 2)) begin
         add_plain();
      end else if (r < 60) begin
         add_rc(1'($urandom_range(0, 1)), pick_rc_len(), $urandom_range(0, 99) < 20,
                pick_word());
      end else if (r < 75) begin
         // A defined-length sequence: its contents are parsed as elements.
         seq_len = $urandom;
         if (seq_len == LENGTH_UNDEF) seq_len = 0;
         put_header(free_group(), 16'($urandom), VR_SQ, seq_len);
         repeat ($urandom_range(1, 2)) add_element(depth + 1);
      end else if (r < 92) begin
         if ($urandom_range(0, 99) < 20)
            add_walk(GROUP_IMAGE, $urandom_range(0, 1) ? ELEM_COLUMNS : ELEM_ROWS, VR_SQ);
         else
            add_walk(free_group(), 16'($urandom),
                     ($urandom_range(0, 99) < 70) ? VR_SQ : pick_wide_vr());
      end else begin
         put_rand($urandom_range(1, 4));
      end
   endfunction

   function automatic void add_pixel(pix_form_e form, int unsigned nbytes);
      int unsigned i;
      case (form)
         PIXF_UNDEF: add_walk(GROUP_PIXEL, ELEM_PIXEL, VR_OB);
         PIXF_SQ:    put_header(GROUP_PIXEL, ELEM_PIXEL, VR_SQ, nbytes);
         default: begin
            if (form == PIXF_WIDE)
               put_header(GROUP_PIXEL, ELEM_PIXEL, $urandom_range(0, 1) ? VR_OW : VR_OB, nbytes);
            else
               put_header(GROUP_PIXEL, ELEM_PIXEL, VR_US, nbytes);
            for (i = 0; i < nbytes / 2; i++) put16(pick_word());
            if (nbytes % 2 != 0) put_rand(1);
         end
      endcase
   endfunction

   function automatic int unsigned pick_pixel_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 20) return 1;
      if (r < 95) return 2 * $urandom_range(1, 16) + $urandom_range(0, 1);
      return $urandom_range(33, 300);
   endfunction

   // ---------------------------------------------------------------------
   // Driving. A beat is presented with nonblocking assignments at the edge
   // and counts as accepted at the first later edge with tready high.
   // ---------------------------------------------------------------------
   task automatic drive_beat(logic [7:0] b, logic s);
      if (!steady) begin
         while ($urandom_range(0, 99) < 12) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, s);
   endtask

   // Sends the first cut bytes of the file; start is raised on the first byte
   // and, for a broken file, again at restart_at.
   task automatic send_stream(int unsigned cut, int restart_at);
      int i;
      for (i = 0; i < int'(cut); i++) drive_beat(stream_q[i], (i == 0) || (i == restart_at));
      counted_items += cut;
   endtask

   // Result side: tready idles at random, and a taken beat is checked at the
   // falling edge so that the order of processes at the edge does not matter.
   initial begin
      result_type seen;
      logic       took;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         took       = !reset && rsp_tvalid && rsp_tready;
         seen.kind  = rsp_tuser;
         seen.value = rsp_tdata;
         seen.last  = rsp_tlast;
         rsp_tready <= steady || ($urandom_range(0, 99) >= 12);
         if (took) begin
            @(negedge clock);
            sb.check_result(seen);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int unsigned file_idx, cut, r, size;
      int          restart_at;
      pix_form_e   form;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'd0;
      req_tuser     = 1'b0;
      steady        = 1'b0;
      counted_items = 0;
      sb = new(PREAMBLE_LEN);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed files. A bad magic, then trailing bytes that must be ignored.
      begin_file(1'b1);
      put_rand(3);
      send_stream(stream_q.size(), -1);

      // Rows and Columns of lengths zero to four, extreme values, a walk, and an odd
      // pixel length whose trailing byte is never reported.
      begin_file(1'b0);
      add_rc(1'b0, 0, 1'b0, 16'h1234);
      add_rc(1'b0, 1, 1'b0, 16'h1234);
      add_rc(1'b0, 2, 1'b0, 16'h0000);
      add_rc(1'b1, 2, 1'b0, 16'hFFFF);
      add_rc(1'b0, 4, 1'b0, pick_word());
      add_rc(1'b1, 3, 1'b0, pick_word());
      add_rc(1'b0, 3, 1'b1, pick_word());
      add_walk(free_group(), 16'($urandom), VR_SQ);
      add_pixel(PIXF_WIDE, 5);
      put_rand(3);
      send_stream(stream_q.size(), -1);

      // Pixel data without words in each of its forms.
      begin_file(1'b0);
      add_pixel(PIXF_WIDE, 0);
      send_stream(stream_q.size(), -1);
      begin_file(1'b0);
      add_pixel(PIXF_SHORT, 1);
      put_rand(2);
      send_stream(stream_q.size(), -1);
      begin_file(1'b0);
      add_rc(1'b1, 2, 1'b0, pick_word());
      add_pixel(PIXF_UNDEF, 0);
      send_stream(stream_q.size(), -1);
      begin_file(1'b0);
      add_pixel(PIXF_SQ, 8);
      put_rand(2);
      send_stream(stream_q.size(), -1);

      // Random files: mostly well formed, with a few bad magics, truncations
      // and restarts part way through.
      file_idx = 0;
      while (counted_items < TARGET_ITEMS) begin
         steady = (file_idx >= 1) && (file_idx < 3);
         begin_file($urandom_range(0, 99) < 5);
         repeat ($urandom_range(2, 8)) add_element(0);
         if ($urandom_range(0, 99) < 92) begin
            r = $urandom_range(0, 99);
            if (r < 70) form = PIXF_WIDE;
            else if (r < 80) form = PIXF_SHORT;
            else if (r < 90) form = PIXF_UNDEF;
            else form = PIXF_SQ;
            add_pixel(form, pick_pixel_len());
         end
         put_rand($urandom_range(0, 4));
         size       = stream_q.size();
         cut        = size;
         restart_at = -1;
         r = $urandom_range(0, 99);
         if (r < 5) cut = $urandom_range(PREAMBLE_LEN, size - 1);
         else if (r < 9) restart_at = $urandom_range(1, size - 1);
         send_stream(cut, restart_at);
         file_idx++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
